@@ rtl/core/ism_pkg.sv @@
// Shared types, sizes and opcodes for the integer stack machine.
// Depends on nothing; every other file refers to it by scoped names.
package ism_pkg;

	localparam int WORD_W      = 32;
	localparam int OP_W        = 4;
	localparam int DEPTH_W     = 7;
	localparam int STACK_DEPTH = 64;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DIV_CNT_W   = $clog2(WORD_W);

	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [SP_W-1:0]      sp_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [DEPTH_W-1:0]   depth_t;
	typedef logic [DIV_CNT_W-1:0] div_cnt_t;

	typedef enum logic [OP_W-1:0] {
		OP_CONST = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_MAX   = 4'd5,
		OP_MIN   = 4'd6,
		OP_NEG   = 4'd7,
		OP_DUP   = 4'd8,
		OP_SWAP  = 4'd9
	} opcode_t;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [WORD_W-1:0] operand_value;
	} cmd_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] top_value;
		logic [DEPTH_W-1:0]       stack_depth;
		logic                     underflow;
		logic                     overflow;
		logic                     divide_by_zero;
	} rsp_t;

	typedef struct packed {
		logic  start;
		word_t dividend;
		word_t divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		word_t quotient;
	} div_rsp_t;

endpackage

@@ rtl/core/integer_stack_machine.sv @@
// Top level of the integer stack machine: sequencer, stack memory, top cache.
// Depends on ism_pkg, ism_alu and ism_divider.
//
//  channel | dir | handshake             | payload
//  cmd     | in  | cmd_valid / cmd_ready | ism_pkg::cmd_t (operation, operand_value)
//  rsp     | out | rsp_valid / rsp_ready | ism_pkg::rsp_t (top, depth, three flags)
//
// One instruction at a time: fetch, execute, one push state per pushed word, then finish;
// DIV with a nonzero divisor waits in its own state on the bit-serial divider.
// Unused opcodes go from execute straight to finish with no change to the stack.
// Reset clears the stack pointer and the sequencer; stack words stay as they are.
// A finished result waits in the output register while the next beat is taken;
// the sequencer holds in its finish state only while that register is still full.
module integer_stack_machine (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ism_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ism_pkg::rsp_t rsp
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FETCH = 7'b0000010,
		ST_EXEC  = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_PUSH1 = 7'b0010000,
		ST_PUSH2 = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t           state_q;
	ism_pkg::sp_t     sp_q;
	ism_pkg::word_t   top_q;
	ism_pkg::opcode_t op_q;
	ism_pkg::word_t   operand_q;
	ism_pkg::word_t   v1_q;
	ism_pkg::word_t   v2_q;
	logic             two_q;
	logic             under_q;
	logic             over_q;
	logic             dz_q;
	logic             rsp_valid_q;
	ism_pkg::rsp_t    rsp_q;

	ism_pkg::word_t stack_mem [ism_pkg::STACK_DEPTH];
	ism_pkg::word_t rd_data_q;
	logic           rd_en;
	ism_pkg::addr_t rd_addr;
	logic           wr_en;
	ism_pkg::word_t wr_data;

	logic              has_a;
	logic              has_b;
	logic              pop_one;
	logic              pop_two;
	ism_pkg::word_t    a;
	ism_pkg::word_t    b;
	logic              under;
	ism_pkg::sp_t      sp_pop;
	ism_pkg::word_t    alu_r;
	logic              room;
	ism_pkg::div_req_t div_req;
	ism_pkg::div_rsp_t div_rsp;

	assign cmd_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// operands: cached top and the second entry read from the stack
	assign has_a   = (sp_q != '0);
	assign has_b   = (sp_q >= ism_pkg::sp_t'(2));
	assign pop_two = op_q inside {ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_MUL,
		ism_pkg::OP_DIV, ism_pkg::OP_MAX, ism_pkg::OP_MIN, ism_pkg::OP_SWAP};
	assign pop_one = op_q inside {ism_pkg::OP_NEG, ism_pkg::OP_DUP};
	assign a       = has_a ? top_q : '1;
	assign b       = has_b ? rd_data_q : '1;
	assign under   = ((pop_one || pop_two) && !has_a) || (pop_two && !has_b);

	// depth after the pops, floored at empty
	always_comb begin
		sp_pop = sp_q;
		if (pop_two) begin
			sp_pop = has_b ? sp_q - ism_pkg::sp_t'(2) : '0;
		end else if (pop_one) begin
			sp_pop = has_a ? sp_q - ism_pkg::sp_t'(1) : '0;
		end
	end

	ism_alu u_alu (
		.op (op_q),
		.a  (a),
		.b  (b),
		.r  (alu_r)
	);

	assign div_req.start    = (state_q == ST_EXEC) && (op_q == ism_pkg::OP_DIV) && (b != '0);
	assign div_req.dividend = a;
	assign div_req.divisor  = b;

	ism_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// stack memory: one write port for pushes, one registered read of the second entry
	assign room    = (sp_q < ism_pkg::sp_t'(ism_pkg::STACK_DEPTH));
	assign rd_en   = (state_q == ST_FETCH) && has_b;
	assign rd_addr = ism_pkg::addr_t'(sp_q - ism_pkg::sp_t'(2));
	assign wr_en   = ((state_q == ST_PUSH1) || (state_q == ST_PUSH2)) && room;
	assign wr_data = (state_q == ST_PUSH2) ? v2_q : v1_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[ism_pkg::addr_t'(sp_q)] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= stack_mem[rd_addr];
		end
	end

	// sequencer and stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sp_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// raise the result beat from the finish state, drop it once taken
			if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					sp_q <= sp_pop;
					case (op_q)
						ism_pkg::OP_CONST, ism_pkg::OP_ADD, ism_pkg::OP_SUB,
						ism_pkg::OP_MUL, ism_pkg::OP_MAX, ism_pkg::OP_MIN,
						ism_pkg::OP_NEG, ism_pkg::OP_DUP, ism_pkg::OP_SWAP:
							state_q <= ST_PUSH1;
						ism_pkg::OP_DIV:
							state_q <= div_req.start ? ST_DIV : ST_PUSH1;
						default:
							state_q <= ST_DONE;
					endcase
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_PUSH1;
					end
				end
				ST_PUSH1: begin
					if (room) begin
						sp_q <= sp_q + ism_pkg::sp_t'(1);
					end
					state_q <= two_q ? ST_PUSH2 : ST_DONE;
				end
				ST_PUSH2: begin
					if (room) begin
						sp_q <= sp_q + ism_pkg::sp_t'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// instruction, push values, flags and the cached top
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			op_q      <= ism_pkg::opcode_t'(cmd.operation);
			operand_q <= cmd.operand_value;
			under_q   <= 1'b0;
			over_q    <= 1'b0;
			dz_q      <= 1'b0;
			two_q     <= 1'b0;
		end
		if (state_q == ST_EXEC) begin
			under_q <= under;
			case (op_q)
				ism_pkg::OP_CONST: v1_q <= operand_q;
				ism_pkg::OP_DUP: begin
					v1_q  <= a;
					v2_q  <= a;
					two_q <= 1'b1;
				end
				ism_pkg::OP_SWAP: begin
					v1_q  <= a;
					v2_q  <= b;
					two_q <= 1'b1;
				end
				ism_pkg::OP_DIV: begin
					v1_q <= '0;
					dz_q <= (b == '0);
				end
				default: v1_q <= alu_r;
			endcase
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			v1_q <= div_rsp.quotient;
		end
		if (state_q == ST_PUSH1 || state_q == ST_PUSH2) begin
			if (room) begin
				top_q <= wr_data;
			end else begin
				over_q <= 1'b1;
			end
		end
		if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.top_value      <= has_a ? top_q : '1;
			rsp_q.stack_depth    <= ism_pkg::depth_t'(sp_q);
			rsp_q.underflow      <= under_q;
			rsp_q.overflow       <= over_q;
			rsp_q.divide_by_zero <= dz_q;
		end
	end

	// the stack never grows past its capacity
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= ism_pkg::sp_t'(ism_pkg::STACK_DEPTH))
		else $error("stack pointer beyond capacity");

	// the pointer moves only while popping or pushing
	a_sp_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_EXEC && state_q != ST_PUSH1 && state_q != ST_PUSH2) |=> $stable(sp_q))
		else $error("stack pointer moved outside execute or push");

	// the divider reports only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide wait");

	// an accepted beat always starts with the operand fetch
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> (state_q == ST_FETCH))
		else $error("accepted beat did not start a fetch");

endmodule

@@ rtl/core/ism_alu.sv @@
// Combinational arithmetic unit: add, sub, low product, signed max/min, negate.
// Depends on ism_pkg for the word type and opcodes.
module ism_alu (
	input  ism_pkg::opcode_t op,
	input  ism_pkg::word_t   a,
	input  ism_pkg::word_t   b,
	output ism_pkg::word_t   r
);

	logic a_gt_b;
	logic a_lt_b;

	// signed compare of the two operands
	assign a_gt_b = $signed(a) > $signed(b);
	assign a_lt_b = $signed(a) < $signed(b);

	// select the operation, wrapping modulo the word size
	always_comb begin
		case (op)
			ism_pkg::OP_ADD: r = a + b;
			ism_pkg::OP_SUB: r = a - b;
			ism_pkg::OP_MUL: r = a * b;
			ism_pkg::OP_MAX: r = a_gt_b ? a : b;
			ism_pkg::OP_MIN: r = a_lt_b ? a : b;
			ism_pkg::OP_NEG: r = '0 - a;
			default:         r = a;
		endcase
	end

endmodule

@@ rtl/core/ism_divider.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on ism_pkg for the word type and request/response structs.
module ism_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  ism_pkg::div_req_t req,
	output ism_pkg::div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	ism_pkg::div_cnt_t cnt_q;
	logic              neg_q;
	ism_pkg::word_t    quo_q;
	ism_pkg::word_t    rem_q;
	ism_pkg::word_t    dvs_q;

	logic [ism_pkg::WORD_W:0]   shifted;
	logic [ism_pkg::WORD_W+1:0] diff;
	logic                       ge;
	ism_pkg::word_t             abs_a;
	ism_pkg::word_t             abs_b;

	// take magnitudes at start
	assign abs_a = req.dividend[ism_pkg::WORD_W-1] ? '0 - req.dividend : req.dividend;
	assign abs_b = req.divisor[ism_pkg::WORD_W-1] ? '0 - req.divisor : req.divisor;

	// one restoring step: shift in the next dividend bit and trial subtract
	assign shifted = {rem_q, quo_q[ism_pkg::WORD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = ~diff[ism_pkg::WORD_W+1];

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ism_pkg::div_cnt_t'(ism_pkg::WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hold and advance the partial remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[ism_pkg::WORD_W-1] ^ req.divisor[ism_pkg::WORD_W-1];
			quo_q <= abs_a;
			dvs_q <= abs_b;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ism_pkg::WORD_W-1:0] : shifted[ism_pkg::WORD_W-1:0];
			quo_q <= {quo_q[ism_pkg::WORD_W-2:0], ge};
		end
	end

	// restore the sign of the quotient
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? '0 - quo_q : quo_q;

endmodule
